// ===== rtl/cmpl_pkg.sv =====
// Shared types, constants and helpers of the chassis motor power limiter.
package cmpl_pkg;

  localparam int NumMotors = 4;
  localparam int CmdW      = 16;
  localparam int CfgW      = 32;
  localparam int CfgIdxW   = 3;

  // Arithmetic widths
  localparam int EstW      = 41;                          // signed Q24.16 estimate
  localparam int TotW      = 40 + $clog2(NumMotors);      // sum of non-negative estimates
  localparam int ScaleBits = 32;                          // Q0.32 scale quotient bits
  localparam int SqrtBits  = 50;                          // root bits
  localparam int QuoBits   = 14;                          // command quotient bits below 16384
  localparam int DW        = 100;                         // discriminant width
  localparam int BqW       = 48;                          // signed linear coefficient
  localparam int NumW      = 51;                          // numerator magnitude

  // Pipeline depth
  localparam int TotStage  = 6;
  localparam int TopStages = 11 + ScaleBits;
  localparam int RootLat   = SqrtBits + QuoBits + 3;
  localparam int Latency   = TopStages + RootLat;

  localparam logic signed [CmdW-1:0] CmdClamp = 16'sd16000;
  localparam logic signed [CmdW-1:0] CmdSat   = 16'sd16384;

  localparam logic [CfgW-1:0] MaxPowerRst    = 32'd0;
  localparam logic [CfgW-1:0] StaticPowerRst = 32'd267452;
  localparam logic [CfgW-1:0] TorqueCoefRst  = 32'd2195604;
  localparam logic [CfgW-1:0] CopperCoefRst  = 32'd135240;
  localparam logic [CfgW-1:0] SpeedCoefRst   = 32'd159759;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxPower    = 3'd0,
    RegStaticPower = 3'd1,
    RegTorqueCoef  = 3'd2,
    RegCopperCoef  = 3'd3,
    RegSpeedCoef   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CmdW-1:0] motor0_command;
    logic signed [CmdW-1:0] motor1_command;
    logic signed [CmdW-1:0] motor2_command;
    logic signed [CmdW-1:0] motor3_command;
    logic signed [CmdW-1:0] motor0_speed;
    logic signed [CmdW-1:0] motor1_speed;
    logic signed [CmdW-1:0] motor2_speed;
    logic signed [CmdW-1:0] motor3_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [CmdW-1:0] motor0_limited;
    logic signed [CmdW-1:0] motor1_limited;
    logic signed [CmdW-1:0] motor2_limited;
    logic signed [CmdW-1:0] motor3_limited;
    logic [31:0]            total_power;
    logic                   limit_active;
  } out_item_t;

  // Per-motor control that travels with the discriminant into the root unit
  typedef struct packed {
    logic signed [CmdW-1:0] cmd;
    logic signed [BqW-1:0]  bq;
    logic                   active;
  } root_ctx_t;

  // Saturate a command to the legal output range
  function automatic logic signed [CmdW-1:0] sat_cmd(input logic signed [CmdW-1:0] c);
    logic signed [CmdW-1:0] r;
    r = c;
    if (c > CmdSat) r = CmdSat;
    if (c < -CmdSat) r = -CmdSat;
    return r;
  endfunction

endpackage

// ===== rtl/chassis_motor_power_limiter_unit.sv =====
// Top level of the chassis motor power limiter.
// Usage: drive item_i (four commands, four speeds) and raise start for one
// cycle; the item is taken at that edge when busy is low. busy stays low, so
// a new item may be started in every cycle. Each item gives exactly one result
// on result_o, marked by done_o for a single cycle; results leave in the order
// the items came in.
// The work is a fixed pipeline: stages form the power estimates and their sum,
// a 32-stage divider forms the scale, further stages form the discriminant, then
// per motor a 50-stage square root, a numerator stage, a range-check stage, a
// 14-stage quotient and a clamp stage. Throughput is one item per cycle.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high;
// write only while no item is in flight. Unknown indexes are ignored.
// Reset clears the in-flight valid bits and returns the registers to their
// defaults. The receiver cannot stall: results are not held.
module chassis_motor_power_limiter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  cmpl_pkg::in_item_t            item_i,
  output logic                          done_o,
  output cmpl_pkg::out_item_t           result_o,
  input  logic                          cfg_we_i,
  input  logic [cmpl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cmpl_pkg::CfgW-1:0]     cfg_data_i
);
  import cmpl_pkg::*;

  typedef struct packed {
    logic signed [CmdW-1:0] cmd;
    logic signed [BqW-1:0]  bq;
    logic signed [EstW-1:0] est;
    logic signed [DW-1:0]   g;
  } mctx_t;

  // Configuration registers
  logic [CfgW-1:0] max_power_q, static_power_q, tc_q, k1_q, k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q    <= MaxPowerRst;
      static_power_q <= StaticPowerRst;
      tc_q           <= TorqueCoefRst;
      k1_q           <= CopperCoefRst;
      k2_q           <= SpeedCoefRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxPower:    max_power_q    <= cfg_data_i;
        RegStaticPower: static_power_q <= cfg_data_i;
        RegTorqueCoef:  tc_q           <= cfg_data_i;
        RegCopperCoef:  k1_q           <= cfg_data_i;
        RegSpeedCoef:   k2_q           <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the free-running data stages
  logic [Latency-1:0] valid_q;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Latency-2:0], accept};
    end
  end

  // Unpack the item
  logic signed [CmdW-1:0] in_cmd [NumMotors];
  logic signed [CmdW-1:0] in_spd [NumMotors];

  always_comb begin
    in_cmd[0] = item_i.motor0_command;
    in_cmd[1] = item_i.motor1_command;
    in_cmd[2] = item_i.motor2_command;
    in_cmd[3] = item_i.motor3_command;
    in_spd[0] = item_i.motor0_speed;
    in_spd[1] = item_i.motor1_speed;
    in_spd[2] = item_i.motor2_speed;
    in_spd[3] = item_i.motor3_speed;
  end

  // Stage 1: magnitudes and small products
  logic signed [CmdW-1:0] s1_cmd_q [NumMotors];
  logic                   s1_cneg_q [NumMotors], s1_sneg_q [NumMotors];
  logic [15:0]            s1_ms_q [NumMotors];
  logic [30:0]            s1_cs_q [NumMotors], s1_ss_q [NumMotors], s1_cc_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      logic [15:0] mc, ms;
      logic [31:0] pcs, pss, pcc;
      mc  = in_cmd[m][CmdW-1] ? 16'(-in_cmd[m]) : 16'(in_cmd[m]);
      ms  = in_spd[m][CmdW-1] ? 16'(-in_spd[m]) : 16'(in_spd[m]);
      pcs = {16'd0, mc} * {16'd0, ms};
      pss = {16'd0, ms} * {16'd0, ms};
      pcc = {16'd0, mc} * {16'd0, mc};
      s1_cmd_q[m]  <= in_cmd[m];
      s1_cneg_q[m] <= in_cmd[m][CmdW-1];
      s1_sneg_q[m] <= in_spd[m][CmdW-1];
      s1_ms_q[m]   <= ms;
      s1_cs_q[m]   <= pcs[30:0];
      s1_ss_q[m]   <= pss[30:0];
      s1_cc_q[m]   <= pcc[30:0];
    end
  end

  // Stage 2: coefficient products
  logic signed [CmdW-1:0] s2_cmd_q [NumMotors];
  logic                   s2_sneg_q [NumMotors], s2_t1neg_q [NumMotors];
  logic [62:0]            s2_t1_q [NumMotors], s2_a2_q [NumMotors], s2_a1_q [NumMotors];
  logic [46:0]            s2_b_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      logic [62:0] pb;
      pb = {47'd0, s1_ms_q[m]} * {31'd0, tc_q};
      s2_cmd_q[m]   <= s1_cmd_q[m];
      s2_sneg_q[m]  <= s1_sneg_q[m];
      s2_t1neg_q[m] <= (s1_cneg_q[m] != s1_sneg_q[m]) && (s1_cs_q[m] != '0);
      s2_t1_q[m]    <= {32'd0, s1_cs_q[m]} * {31'd0, tc_q};
      s2_a2_q[m]    <= {32'd0, s1_ss_q[m]} * {31'd0, k2_q};
      s2_a1_q[m]    <= {32'd0, s1_cc_q[m]} * {31'd0, k1_q};
      s2_b_q[m]     <= pb[46:0];
    end
  end

  // Stage 3: positive power terms and square partials of the linear term
  logic signed [CmdW-1:0] s3_cmd_q [NumMotors];
  logic                   s3_sneg_q [NumMotors], s3_t1neg_q [NumMotors];
  logic [62:0]            s3_t1_q [NumMotors], s3_c0_q [NumMotors];
  logic [63:0]            s3_pos_q [NumMotors], s3_bll_q [NumMotors];
  logic [46:0]            s3_blh_q [NumMotors], s3_b_q [NumMotors];
  logic [29:0]            s3_bhh_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      logic [63:0] sp24;
      sp24 = {8'd0, static_power_q, 24'd0};
      s3_cmd_q[m]   <= s2_cmd_q[m];
      s3_sneg_q[m]  <= s2_sneg_q[m];
      s3_t1neg_q[m] <= s2_t1neg_q[m];
      s3_t1_q[m]    <= s2_t1_q[m];
      s3_b_q[m]     <= s2_b_q[m];
      s3_pos_q[m]   <= {1'b0, s2_a2_q[m]} + {1'b0, s2_a1_q[m]} + sp24;
      s3_c0_q[m]    <= s2_a2_q[m] + sp24[62:0];
      s3_bll_q[m]   <= {32'd0, s2_b_q[m][31:0]} * {32'd0, s2_b_q[m][31:0]};
      s3_blh_q[m]   <= {15'd0, s2_b_q[m][31:0]} * {32'd0, s2_b_q[m][46:32]};
      s3_bhh_q[m]   <= {15'd0, s2_b_q[m][46:32]} * {15'd0, s2_b_q[m][46:32]};
    end
  end

  // Stage 4: signed estimate, B squared, k1*C0 partials
  logic signed [CmdW-1:0] s4_cmd_q [NumMotors];
  logic signed [BqW-1:0]  s4_bq_q [NumMotors];
  logic signed [EstW-1:0] s4_est_q [NumMotors];
  logic [93:0]            s4_bb_q [NumMotors];
  logic [63:0]            s4_pl_q [NumMotors];
  logic [62:0]            s4_ph_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      logic signed [64:0] diff;
      if (s3_t1neg_q[m]) begin
        diff = $signed({1'b0, s3_pos_q[m]}) - $signed({2'b00, s3_t1_q[m]});
      end else begin
        diff = $signed({1'b0, s3_pos_q[m]}) + $signed({2'b00, s3_t1_q[m]});
      end
      s4_cmd_q[m] <= s3_cmd_q[m];
      s4_bq_q[m]  <= s3_sneg_q[m] ? -$signed({1'b0, s3_b_q[m]}) : $signed({1'b0, s3_b_q[m]});
      s4_est_q[m] <= diff[64:24];
      s4_bb_q[m]  <= {30'd0, s3_bll_q[m]} + {14'd0, s3_blh_q[m], 33'd0}
                   + {s3_bhh_q[m], 64'd0};
      s4_pl_q[m]  <= {32'd0, s3_c0_q[m][31:0]} * {32'd0, k1_q};
      s4_ph_q[m]  <= {32'd0, s3_c0_q[m][62:32]} * {31'd0, k1_q};
    end
  end

  // Stage 5: total of non-negative estimates, k1*C0
  logic signed [CmdW-1:0] s5_cmd_q [NumMotors];
  logic signed [BqW-1:0]  s5_bq_q [NumMotors];
  logic signed [EstW-1:0] s5_est_q [NumMotors];
  logic [93:0]            s5_bb_q [NumMotors];
  logic [94:0]            s5_kc_q [NumMotors];
  logic [TotW-1:0]        s5_tot_q;
  logic [TotW-1:0]        tot_sum;

  always_comb begin
    tot_sum = '0;
    for (int m = 0; m < NumMotors; m++) begin
      if (!s4_est_q[m][EstW-1]) begin
        tot_sum = tot_sum + {{(TotW-40){1'b0}}, s4_est_q[m][39:0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s5_tot_q <= tot_sum;
    for (int m = 0; m < NumMotors; m++) begin
      s5_cmd_q[m] <= s4_cmd_q[m];
      s5_bq_q[m]  <= s4_bq_q[m];
      s5_est_q[m] <= s4_est_q[m];
      s5_bb_q[m]  <= s4_bb_q[m];
      s5_kc_q[m]  <= {s4_ph_q[m], 32'd0} + {31'd0, s4_pl_q[m]};
    end
  end

  // Stage 6: limit decision, saturated total, partial discriminant G
  mctx_t           s6_ctx_q [NumMotors];
  logic [TotW-1:0] s6_tot_q;
  logic [31:0]     s6_totsat_q;
  logic            s6_lim_q;

  always_ff @(posedge clk_i) begin
    s6_tot_q    <= s5_tot_q;
    s6_lim_q    <= s5_tot_q > {{(TotW-32){1'b0}}, max_power_q};
    s6_totsat_q <= (|s5_tot_q[TotW-1:32]) ? '1 : s5_tot_q[31:0];
    for (int m = 0; m < NumMotors; m++) begin
      s6_ctx_q[m].cmd <= s5_cmd_q[m];
      s6_ctx_q[m].bq  <= s5_bq_q[m];
      s6_ctx_q[m].est <= s5_est_q[m];
      s6_ctx_q[m].g   <= $signed({6'd0, s5_bb_q[m]}) - $signed({3'd0, s5_kc_q[m], 2'b00});
    end
  end

  // Scale divider: max_power * 2^32 / total, one quotient bit per stage
  logic [TotW:0]        dv_rem_q [ScaleBits];
  logic [ScaleBits-1:0] dv_quo_q [ScaleBits];
  logic [TotW-1:0]      dv_tot_q [ScaleBits];
  logic                 dv_lim_q [ScaleBits];
  mctx_t                dv_ctx_q [ScaleBits][NumMotors];

  for (genvar j = 0; j < ScaleBits; j++) begin : g_div
    logic [TotW:0]        rem_in, sh;
    logic [ScaleBits-1:0] quo_in;
    logic [TotW-1:0]      tot_in;
    logic                 lim_in, ge;
    mctx_t                ctx_in [NumMotors];

    if (j == 0) begin : g_first
      assign rem_in = {{(TotW+1-CfgW){1'b0}}, max_power_q};
      assign quo_in = '0;
      assign tot_in = s6_tot_q;
      assign lim_in = s6_lim_q;
      assign ctx_in = s6_ctx_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[j-1];
      assign quo_in = dv_quo_q[j-1];
      assign tot_in = dv_tot_q[j-1];
      assign lim_in = dv_lim_q[j-1];
      assign ctx_in = dv_ctx_q[j-1];
    end

    assign sh = {rem_in[TotW-1:0], 1'b0};
    assign ge = (sh >= {1'b0, tot_in});

    always_ff @(posedge clk_i) begin
      dv_rem_q[j] <= ge ? sh - {1'b0, tot_in} : sh;
      dv_quo_q[j] <= {quo_in[ScaleBits-2:0], ge};
      dv_tot_q[j] <= tot_in;
      dv_lim_q[j] <= lim_in;
      dv_ctx_q[j] <= ctx_in;
    end
  end

  // Scaled power partials: est * scale / 2^32
  localparam int DL = ScaleBits - 1;
  logic [39:0]           sa_ph_q [NumMotors];
  logic [63:0]           sa_pl_q [NumMotors];
  logic                  sa_act_q [NumMotors];
  mctx_t                 sa_ctx_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      sa_ph_q[m]  <= {32'd0, dv_ctx_q[DL][m].est[39:32]} * {8'd0, dv_quo_q[DL]};
      sa_pl_q[m]  <= {32'd0, dv_ctx_q[DL][m].est[31:0]} * {32'd0, dv_quo_q[DL]};
      sa_act_q[m] <= dv_lim_q[DL] && !dv_ctx_q[DL][m].est[EstW-1];
      sa_ctx_q[m] <= dv_ctx_q[DL][m];
    end
  end

  // Scaled power
  logic [39:0] sb_sp_q [NumMotors];
  logic        sb_act_q [NumMotors];
  mctx_t       sb_ctx_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      sb_sp_q[m]  <= sa_ph_q[m] + {8'd0, sa_pl_q[m][63:32]};
      sb_act_q[m] <= sa_act_q[m];
      sb_ctx_q[m] <= sa_ctx_q[m];
    end
  end

  // k1 * scaled power partials
  logic [63:0] sc_hl_q [NumMotors];
  logic [39:0] sc_hh_q [NumMotors];
  logic        sc_act_q [NumMotors];
  mctx_t       sc_ctx_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      sc_hl_q[m]  <= {32'd0, sb_sp_q[m][31:0]} * {32'd0, k1_q};
      sc_hh_q[m]  <= {32'd0, sb_sp_q[m][39:32]} * {8'd0, k1_q};
      sc_act_q[m] <= sb_act_q[m];
      sc_ctx_q[m] <= sb_ctx_q[m];
    end
  end

  // k1 * scaled power
  logic [71:0] sd_h_q [NumMotors];
  logic        sd_act_q [NumMotors];
  mctx_t       sd_ctx_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      sd_h_q[m]   <= {sc_hh_q[m], 32'd0} + {8'd0, sc_hl_q[m]};
      sd_act_q[m] <= sc_act_q[m];
      sd_ctx_q[m] <= sc_ctx_q[m];
    end
  end

  // Discriminant, negative values taken as zero
  logic [DW-1:0] se_d_q [NumMotors];
  root_ctx_t     se_ctx_q [NumMotors];

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      logic signed [DW-1:0] dsum;
      dsum = sd_ctx_q[m].g + $signed({2'b00, sd_h_q[m], 26'd0});
      se_d_q[m]          <= dsum[DW-1] ? '0 : dsum;
      se_ctx_q[m].cmd    <= sd_ctx_q[m].cmd;
      se_ctx_q[m].bq     <= sd_ctx_q[m].bq;
      se_ctx_q[m].active <= sd_act_q[m];
    end
  end

  // Per-motor root units
  logic signed [CmdW-1:0] limited [NumMotors];

  for (genvar m = 0; m < NumMotors; m++) begin : g_motor
    cmpl_root u_root (
      .clk_i     (clk_i),
      .d_i       (se_d_q[m]),
      .ctx_i     (se_ctx_q[m]),
      .k1_i      (k1_q),
      .limited_o (limited[m])
    );
  end

  // Delay the total and limit flag to meet the commands
  localparam int TotDly = Latency - TotStage;
  logic [31:0] td_tot_q [TotDly];
  logic        td_lim_q [TotDly];

  always_ff @(posedge clk_i) begin
    td_tot_q[0] <= s6_totsat_q;
    td_lim_q[0] <= s6_lim_q;
    for (int i = 1; i < TotDly; i++) begin
      td_tot_q[i] <= td_tot_q[i-1];
      td_lim_q[i] <= td_lim_q[i-1];
    end
  end

  // Drive the result
  assign done_o                  = valid_q[Latency-1];
  assign result_o.motor0_limited = limited[0];
  assign result_o.motor1_limited = limited[1];
  assign result_o.motor2_limited = limited[2];
  assign result_o.motor3_limited = limited[3];
  assign result_o.total_power    = td_tot_q[TotDly-1];
  assign result_o.limit_active   = td_lim_q[TotDly-1];

endmodule

// ===== rtl/cmpl_root.sv =====
// Per-motor root unit: pipelined square root, quotient and command clamp.
module cmpl_root (
  input  logic                           clk_i,
  input  logic [cmpl_pkg::DW-1:0]        d_i,
  input  cmpl_pkg::root_ctx_t            ctx_i,
  input  logic [cmpl_pkg::CfgW-1:0]      k1_i,
  output logic signed [cmpl_pkg::CmdW-1:0] limited_o
);
  import cmpl_pkg::*;

  // Square root stages, one result bit each
  logic [DW-1:0]       sq_rem_q [SqrtBits];
  logic [SqrtBits-1:0] sq_res_q [SqrtBits];
  root_ctx_t           sq_ctx_q [SqrtBits];

  for (genvar s = 0; s < SqrtBits; s++) begin : g_sqrt
    localparam int Bt = SqrtBits - 1 - s;
    logic [DW-1:0]       rem_in, trial;
    logic [SqrtBits-1:0] res_in;
    root_ctx_t           ctx_in;
    logic                ge;

    if (s == 0) begin : g_first
      assign rem_in = d_i;
      assign res_in = '0;
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign rem_in = sq_rem_q[s-1];
      assign res_in = sq_res_q[s-1];
      assign ctx_in = sq_ctx_q[s-1];
    end

    // Try setting this bit: (res + 2^b)^2 - res^2 = res*2^(b+1) + 2^(2b)
    assign trial = ({{(DW-SqrtBits){1'b0}}, res_in} << (Bt + 1))
                 | ({{(DW-1){1'b0}}, 1'b1} << (2 * Bt));
    assign ge = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      sq_rem_q[s] <= ge ? rem_in - trial : rem_in;
      sq_res_q[s] <= ge ? (res_in | (SqrtBits'(1) << Bt)) : res_in;
      sq_ctx_q[s] <= ctx_in;
    end
  end

  // Form the numerator on the branch that matches the command sign
  logic signed [NumW:0] num;
  logic                 cpos;
  logic [NumW-1:0]      nm_abs_q;
  logic                 nm_neg_q, nm_zero_q;
  root_ctx_t            nm_ctx_q;

  always_comb begin
    cpos = !sq_ctx_q[SqrtBits-1].cmd[CmdW-1] && (|sq_ctx_q[SqrtBits-1].cmd);
    if (cpos) begin
      num = $signed({2'b00, sq_res_q[SqrtBits-1]})
          - $signed({{(NumW+1-BqW){sq_ctx_q[SqrtBits-1].bq[BqW-1]}},
                     sq_ctx_q[SqrtBits-1].bq});
    end else begin
      num = -$signed({{(NumW+1-BqW){sq_ctx_q[SqrtBits-1].bq[BqW-1]}},
                      sq_ctx_q[SqrtBits-1].bq})
          - $signed({2'b00, sq_res_q[SqrtBits-1]});
    end
  end

  always_ff @(posedge clk_i) begin
    nm_abs_q  <= num[NumW] ? NumW'(-num) : num[NumW-1:0];
    nm_neg_q  <= num[NumW];
    nm_zero_q <= (num == '0);
    nm_ctx_q  <= sq_ctx_q[SqrtBits-1];
  end

  // Detect a quotient at or beyond 16384; a zero k1 lands here too
  logic [CfgW:0]   dvs;
  logic [NumW-1:0] ov_lim;
  logic [NumW-1:0] ov_rem_q;
  logic            ov_ovf_q, ov_neg_q, ov_zero_q;
  root_ctx_t       ov_ctx_q;

  assign dvs    = {k1_i, 1'b0};
  assign ov_lim = NumW'({dvs, {QuoBits{1'b0}}});

  always_ff @(posedge clk_i) begin
    ov_rem_q  <= nm_abs_q;
    ov_ovf_q  <= (nm_abs_q >= ov_lim);
    ov_neg_q  <= nm_neg_q;
    ov_zero_q <= nm_zero_q;
    ov_ctx_q  <= nm_ctx_q;
  end

  // Restoring division stages, one quotient bit each
  logic [NumW-1:0]    qs_rem_q  [QuoBits];
  logic [QuoBits-1:0] qs_quo_q  [QuoBits];
  logic               qs_ovf_q  [QuoBits];
  logic               qs_neg_q  [QuoBits];
  logic               qs_zero_q [QuoBits];
  root_ctx_t          qs_ctx_q  [QuoBits];

  for (genvar j = 0; j < QuoBits; j++) begin : g_quo
    localparam int Kb = QuoBits - 1 - j;
    logic [NumW-1:0]    rem_in, t;
    logic [QuoBits-1:0] quo_in;
    logic               ovf_in, neg_in, zero_in, ge;
    root_ctx_t          ctx_in;

    if (j == 0) begin : g_first
      assign rem_in  = ov_rem_q;
      assign quo_in  = '0;
      assign ovf_in  = ov_ovf_q;
      assign neg_in  = ov_neg_q;
      assign zero_in = ov_zero_q;
      assign ctx_in  = ov_ctx_q;
    end else begin : g_next
      assign rem_in  = qs_rem_q[j-1];
      assign quo_in  = qs_quo_q[j-1];
      assign ovf_in  = qs_ovf_q[j-1];
      assign neg_in  = qs_neg_q[j-1];
      assign zero_in = qs_zero_q[j-1];
      assign ctx_in  = qs_ctx_q[j-1];
    end

    assign t  = NumW'(dvs) << Kb;
    assign ge = (rem_in >= t);

    always_ff @(posedge clk_i) begin
      qs_rem_q[j]  <= ge ? rem_in - t : rem_in;
      qs_quo_q[j]  <= ge ? (quo_in | (QuoBits'(1) << Kb)) : quo_in;
      qs_ovf_q[j]  <= ovf_in;
      qs_neg_q[j]  <= neg_in;
      qs_zero_q[j] <= zero_in;
      qs_ctx_q[j]  <= ctx_in;
    end
  end

  // Apply sign, one-sided clamp, and pass-through for motors left alone
  logic [QuoBits:0]       mag;
  logic signed [CmdW-1:0] v;
  logic                   fpos;
  root_ctx_t              fc;

  always_comb begin
    fc   = qs_ctx_q[QuoBits-1];
    fpos = !fc.cmd[CmdW-1] && (|fc.cmd);
    if (qs_zero_q[QuoBits-1]) begin
      mag = '0;
    end else if (qs_ovf_q[QuoBits-1]) begin
      mag = (QuoBits+1)'(1) << QuoBits;
    end else begin
      mag = {1'b0, qs_quo_q[QuoBits-1]};
    end
    v = qs_neg_q[QuoBits-1] ? -$signed(CmdW'(mag)) : $signed(CmdW'(mag));
    if (fpos && v > CmdClamp) v = CmdClamp;
    if (!fpos && v < -CmdClamp) v = -CmdClamp;
    if (!fc.active) v = sat_cmd(fc.cmd);
  end

  always_ff @(posedge clk_i) begin
    limited_o <= v;
  end

endmodule

// ===== rtl/cmpl_chk.sv =====
// Port-level checker for the chassis motor power limiter, bound to the top level.
module cmpl_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input cmpl_pkg::in_item_t  item_i,
  input logic                done_o,
  input cmpl_pkg::out_item_t result_o
);
  import cmpl_pkg::*;

  // Every result comes from an item taken a fixed latency earlier
  a_done_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without a matching item");

  // A rescale needs a non-zero total
  a_limit_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.limit_active |-> result_o.total_power != 32'd0)
    else $error("limit active with zero total");

  // Limited commands of motors 0 and 3 stay in the legal range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.motor0_limited <= CmdSat && result_o.motor0_limited >= -CmdSat
            && result_o.motor3_limited <= CmdSat && result_o.motor3_limited >= -CmdSat)
    else $error("limited command out of range");

  // Without a limit, an in-range command of motor 0 passes through unchanged
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.limit_active
      && $past(item_i.motor0_command, Latency) <= CmdSat
      && $past(item_i.motor0_command, Latency) >= -CmdSat
      |-> result_o.motor0_limited == $past(item_i.motor0_command, Latency))
    else $error("unlimited command changed");

endmodule

bind chassis_motor_power_limiter_unit cmpl_chk u_cmpl_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== sim/chassis_motor_power_limiter_checker.sv =====
// Checker for the chassis motor power limiter: predicts each result and compares.
module chassis_motor_power_limiter_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  cmpl_pkg::in_item_t            item_i,
  input  logic                          done_i,
  input  cmpl_pkg::out_item_t           result_i,
  input  logic                          cfg_we_i,
  input  logic [cmpl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cmpl_pkg::CfgW-1:0]     cfg_data_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            limited_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmpl_pkg::*;

  bit [31:0] max_pw, static_pw, torque_k, copper_k, speed_k;
  out_item_t limited_q[$];
  int        err_cnt = 0;
  int        lim_cnt = 0;

  assign pending_o      = limited_q.size();
  assign errors_o       = err_cnt;
  assign limited_seen_o = lim_cnt;

  task automatic report(input string msg);
    $display("%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Q24.16 estimate, floor of the exact Q.40 power (may be negative)
  function automatic longint power_est(input int c, input int s);
    bit [127:0] mc, ms, cs, t1, pos;
    bit         neg;
    mc  = (c < 0) ? -c : c;
    ms  = (s < 0) ? -s : s;
    cs  = mc * ms;
    t1  = cs * 128'(torque_k);
    pos = ms * ms * 128'(speed_k) + mc * mc * 128'(copper_k) + (128'(static_pw) << 24);
    neg = ((c < 0) != (s < 0)) && (cs != 0);
    if (!neg) return longint'((pos + t1) >> 24);
    if (pos >= t1) return longint'((pos - t1) >> 24);
    return -longint'(((t1 - pos) + 128'hFFFFFF) >> 24);
  endfunction

  // Solve for the command that draws the scaled power, clamped on its own side
  function automatic longint solve_cmd(input int c, input int s, input bit [127:0] sp);
    bit [127:0] a, ms, bmag, bb, pos2, d, e, r, cand;
    bit [63:0]  m;
    longint     bq, cq, num, q;
    ms   = (s < 0) ? -s : s;
    a    = 128'(copper_k);
    bmag = ms * 128'(torque_k);
    bq   = (s < 0) ? -longint'(bmag) : longint'(bmag);
    pos2 = ms * ms * 128'(speed_k) + (128'(static_pw) << 24);
    cq   = longint'(pos2[63:0] - 64'(sp << 24));
    bb   = bmag * bmag;
    if (cq <= 0) begin
      d = bb + ((a * 128'(64'(-cq))) << 2);
    end else begin
      e = (a * 128'(64'(cq))) << 2;
      d = (e > bb) ? 128'd0 : bb - e;
    end
    r = 0;
    for (int b = 49; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= d) r = cand;
    end
    num = (c > 0) ? longint'(r) - bq : -bq - longint'(r);
    if (a == 0) begin
      q = (num > 0) ? (64'sd1 <<< 20) : ((num < 0) ? -(64'sd1 <<< 20) : 0);
    end else begin
      m = 64'((num < 0) ? -num : num) / 64'(2 * a);
      q = (num < 0) ? -longint'(m) : longint'(m);
    end
    if (c > 0) begin
      if (q > 16000) q = 16000;
    end else begin
      if (q < -16000) q = -16000;
    end
    return q;
  endfunction

  function automatic logic signed [CmdW-1:0] sat16(input longint v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return CmdW'(v);
  endfunction

  function automatic out_item_t limit_item(input in_item_t it);
    int         cmd[NumMotors], spd[NumMotors];
    longint     est[NumMotors], res[NumMotors];
    bit [63:0]  total, scale;
    bit [127:0] e, sp;
    bit         lim;
    out_item_t  o;
    cmd = '{it.motor0_command, it.motor1_command, it.motor2_command, it.motor3_command};
    spd = '{it.motor0_speed, it.motor1_speed, it.motor2_speed, it.motor3_speed};
    total = 0;
    scale = 0;
    for (int i = 0; i < NumMotors; i++) begin
      est[i] = power_est(cmd[i], spd[i]);
      if (est[i] >= 0) total += 64'(est[i]);
    end
    lim = total > 64'(max_pw);
    if (lim) scale = {max_pw, 32'd0} / total;
    for (int i = 0; i < NumMotors; i++) begin
      res[i] = cmd[i];
      if (lim && est[i] >= 0) begin
        e  = 128'(est[i]);
        sp = (e >> 32) * 128'(scale) + (((e & 128'hFFFFFFFF) * 128'(scale)) >> 32);
        res[i] = solve_cmd(cmd[i], spd[i], sp);
      end
    end
    o.motor0_limited = sat16(res[0]);
    o.motor1_limited = sat16(res[1]);
    o.motor2_limited = sat16(res[2]);
    o.motor3_limited = sat16(res[3]);
    o.total_power    = (total > 64'hFFFFFFFF) ? 32'hFFFFFFFF : total[31:0];
    o.limit_active   = lim;
    return o;
  endfunction

  // Track registers, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t x;
    if (!rst_ni) begin
      max_pw    = MaxPowerRst;
      static_pw = StaticPowerRst;
      torque_k  = TorqueCoefRst;
      copper_k  = CopperCoefRst;
      speed_k   = SpeedCoefRst;
      limited_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMaxPower:    max_pw    = cfg_data_i;
          RegStaticPower: static_pw = cfg_data_i;
          RegTorqueCoef:  torque_k  = cfg_data_i;
          RegCopperCoef:  copper_k  = cfg_data_i;
          RegSpeedCoef:   speed_k   = cfg_data_i;
          default: ;
        endcase
      end
      if (done_i) begin
        if (limited_q.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          x = limited_q.pop_front();
          if (result_i.limit_active) lim_cnt++;
          if (result_i.motor0_limited !== x.motor0_limited)
            report($sformatf("motor0 got %0d want %0d", result_i.motor0_limited,
                             x.motor0_limited));
          if (result_i.motor1_limited !== x.motor1_limited)
            report($sformatf("motor1 got %0d want %0d", result_i.motor1_limited,
                             x.motor1_limited));
          if (result_i.motor2_limited !== x.motor2_limited)
            report($sformatf("motor2 got %0d want %0d", result_i.motor2_limited,
                             x.motor2_limited));
          if (result_i.motor3_limited !== x.motor3_limited)
            report($sformatf("motor3 got %0d want %0d", result_i.motor3_limited,
                             x.motor3_limited));
          if (result_i.total_power !== x.total_power)
            report($sformatf("total_power got %0h want %0h", result_i.total_power,
                             x.total_power));
          if (result_i.limit_active !== x.limit_active)
            report($sformatf("limit_active got %b want %b", result_i.limit_active,
                             x.limit_active));
        end
      end
      if (start_i && !busy_i) limited_q.push_back(limit_item(item_i));
    end
  end

endmodule

// ===== sim/chassis_motor_power_limiter_unit_test.sv =====
// Testbench top for the chassis motor power limiter: stimulus and verdict.
module chassis_motor_power_limiter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cmpl_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            item_i = '0;
  logic                done_o;
  out_item_t           result_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  int                  errors, pending, limited_seen, items_sent, cycles;
  bit                  allow_idle;

  always #10 clk_i = ~clk_i;

  chassis_motor_power_limiter_unit DUT (.*);

  chassis_motor_power_limiter_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .item_i, .done_i(done_o),
    .result_i(result_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .limited_seen_o(limited_seen)
  );

  // Hard stop
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item and hold it until taken, then maybe idle
  task automatic send_item(input in_item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Drain the pipeline, then write one register
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_cmd();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [15:0] rand_speed();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 18000)) - 9000);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.motor0_command = rand_cmd();
    it.motor1_command = rand_cmd();
    it.motor2_command = rand_cmd();
    it.motor3_command = rand_cmd();
    it.motor0_speed   = rand_speed();
    it.motor1_speed   = rand_speed();
    it.motor2_speed   = rand_speed();
    it.motor3_speed   = rand_speed();
    return it;
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_item(rand_item());
  endtask

  function automatic in_item_t pack4(input int c0, c1, c2, c3, s0, s1, s2, s3);
    return '{16'(c0), 16'(c1), 16'(c2), 16'(c3), 16'(s0), 16'(s1), 16'(s2), 16'(s3)};
  endfunction

  initial begin
    allow_idle = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners under reset defaults (max_power 0: every item with a positive total is limited)
    send_item(pack4(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(pack4(16384, -16384, 16000, -16000, 32767, -32768, 8000, -8000));
    send_item(pack4(16000, -16000, 12000, -500, -8000, 8000, 3000, -3000));
    send_item(pack4(32767, -32768, -1, 1, 32767, -32768, -1, 1));
    send_item(pack4(-32768, 32767, 0, 0, 0, 0, 32767, -32768));
    write_reg(RegMaxPower, 32'd20 << 16);
    send_item(pack4(16384, -16384, 16384, -16384, 32767, 32767, -32768, -32768));
    send_item(pack4(16000, 8000, -8000, 0, 9000, -9000, 9000, 0));
    send_item(pack4(1, -1, 16384, 100, -32768, 32767, 1, -1));
    send_item(pack4(-32768, 32767, -16384, 16384, 5, -5, 0, 0));
    send_item(pack4(4000, 4000, 4000, 4000, 4000, 4000, 4000, 4000));
    // Negative-power motors beside a limited one
    send_item(pack4(16000, 16000, 2000, 0, -6000, -6000, 9000, 0));

    // Moderate limit, default coefficients
    write_reg(RegMaxPower, 32'd60 << 16);
    send_random(150);

    // Zero copper loss: infinite quotient path
    write_reg(RegCopperCoef, 32'd0);
    write_reg(RegMaxPower, 32'd30 << 16);
    send_random(60);

    // Random coefficients throughout
    write_reg(RegMaxPower, $urandom_range(0, 32'h00FF_FFFF));
    write_reg(RegStaticPower, $urandom);
    write_reg(RegTorqueCoef, $urandom);
    write_reg(RegCopperCoef, $urandom);
    write_reg(RegSpeedCoef, $urandom);
    send_random(60);

    // All registers at their top value: saturating total
    write_reg(RegMaxPower, 32'hFFFF_FFFF);
    write_reg(RegStaticPower, 32'hFFFF_FFFF);
    write_reg(RegTorqueCoef, 32'hFFFF_FFFF);
    write_reg(RegCopperCoef, 32'hFFFF_FFFF);
    write_reg(RegSpeedCoef, 32'hFFFF_FFFF);
    send_item(pack4(32767, -32768, 16384, -16384, 32767, -32768, -32768, 32767));
    send_random(60);

    // All registers at zero: no power, no limit
    write_reg(RegMaxPower, 32'd0);
    write_reg(RegStaticPower, 32'd0);
    write_reg(RegTorqueCoef, 32'd0);
    write_reg(RegCopperCoef, 32'd0);
    write_reg(RegSpeedCoef, 32'd0);
    send_random(40);

    // Back to typical values; an unknown index must leave them alone
    write_reg(RegStaticPower, StaticPowerRst);
    write_reg(RegTorqueCoef, TorqueCoefRst);
    write_reg(RegCopperCoef, CopperCoefRst);
    write_reg(RegSpeedCoef, SpeedCoefRst);
    write_reg(RegMaxPower, 32'd100 << 16);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_random(120);
    allow_idle = 1'b0;
    send_random(100);
    start <= 1'b0;

    // Drain
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);

    $display("Sent %0d items over eight register settings; %0d results were power limited",
             items_sent, limited_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
